// ----- src/nsr_pkg.sv -----
// Package for the nearest sphere on ray search block.
// Holds shared constants, the controller state type and the command/status structs.
`timescale 1ns / 1ps

package nsr_pkg;

  // Default table depth.
  localparam int SLOTS_DEF = 256;

  // Field widths fixed by the interface.
  localparam int VEC_W  = 24;
  localparam int RAD_W  = 8;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;
  localparam int ENTRY_W = 3 * VEC_W + RAD_W;

  // Request kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDQ,
    ST_CAPQ,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input request taken this cycle
    logic capture_q;  // latch querying sphere and move length squared
    logic issue;      // read the next scan slot
    logic push;       // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every active slot has been issued
    logic pipe_busy;  // candidates still in flight
    logic out_busy;   // result register full and not taken this cycle
  } status_t;

endpackage

// ----- src/nsr_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module nsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/nsr_ctrl.sv -----
// Controller state machine for the nearest sphere search.
// Depends on nsr_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps

module nsr_ctrl
  import nsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_kind,
  input  logic    in_slot_ok,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_QUERY) begin
          state_nxt = in_slot_ok ? ST_RDQ : ST_DONE;
        end
      end
      ST_RDQ:  state_nxt = ST_CAPQ;
      ST_CAPQ: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.capture_q = 1'b0;
    cmd.issue     = 1'b0;
    cmd.push      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CAPQ: cmd.capture_q = 1'b1;
      ST_SCAN: cmd.issue = !status.scan_done;
      ST_DONE: cmd.push = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- src/nsr_dp.sv -----
// Datapath: sphere table, scan counter, six-stage candidate test and result register.
// Depends on nsr_pkg and nsr_ram.
`timescale 1ns / 1ps

module nsr_dp
  import nsr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_active_count,
  input  logic                     in_kind,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [VEC_W-1:0]  in_vec_x,
  input  logic signed [VEC_W-1:0]  in_vec_y,
  input  logic signed [VEC_W-1:0]  in_vec_z,
  input  logic [RAD_W-1:0]         in_radius,
  output logic                     in_slot_ok,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic [SLOT_W-1:0]        out_nearest_slot
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;

  // Configuration and query context.
  logic [CNT_W-1:0]        active_r;
  logic [SLOT_W-1:0]       slot_r;
  logic signed [VEC_W-1:0] vx_r, vy_r, vz_r;
  logic signed [VEC_W-1:0] qx_r, qy_r, qz_r;
  logic [RAD_W-1:0]        r1_r;
  logic [46:0]             sqx_r, sqy_r, sqz_r;
  logic [47:0]             dd_r;
  logic [CW-1:0]           idx_r;
  logic [LW-1:0]           limit;

  // Table port.
  logic                    mem_we;
  logic [AW-1:0]           mem_raddr;
  logic [ENTRY_W-1:0]      mem_rdata;
  logic signed [VEC_W-1:0] mx, my, mz;
  logic [RAD_W-1:0]        mr;

  // Pipeline registers.
  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [CW-1:0]           i1_r, i2_r, i3_r, i4_r, i5_r, i6_r;
  logic                    k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic signed [24:0]      px_r, py_r, pz_r;
  logic [8:0]              rs_r;
  logic signed [48:0]      pxvx_r, pyvy_r, pzvz_r;
  logic signed [48:0]      pyvz_r, pzvy_r, pzvx_r, pxvz_r, pxvy_r, pyvx_r;
  logic [17:0]             r2_r;
  logic signed [50:0]      dot_r;
  logic signed [49:0]      cx_r, cy_r, cz_r;
  logic [41:0]             bl_r, bh_r;
  logic [49:0]             proj4;
  logic [48:0]             cmx, cmy, cmz;
  logic [49:0]             proj5_r;
  logic [47:0]             hhx_r, hhy_r, hhz_r;
  logic [48:0]             hlx_r, hly_r, hlz_r;
  logic [49:0]             llx_r, lly_r, llz_r;
  logic [81:0]             bound5_r;
  logic [49:0]             proj6_r;
  logic [101:0]            cross6_r;
  logic [101:0]            bound6_r;
  logic                    reach6_r;
  logic                    pass6;

  // Best candidate and result register.
  logic                    found_r;
  logic [CW-1:0]           best_r;
  logic [49:0]             best_proj_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [SLOT_W-1:0]       out_slot_r;

  assign in_slot_ok = LW'(in_slot) < LW'(SLOTS);
  assign limit      = (LW'(active_r) > LW'(SLOTS)) ? LW'(SLOTS) : LW'(active_r);

  // Active count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_active_count;
    end
  end

  // Sphere table; loads write it, queries read the querying slot then scan.
  assign mem_we    = cmd.accept && in_kind == KIND_LOAD && in_slot_ok;
  assign mem_raddr = cmd.issue ? idx_r[AW-1:0] : AW'(slot_r);

  nsr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_slot)),
    .wdata ({in_vec_x, in_vec_y, in_vec_z, in_radius}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign {mx, my, mz, mr} = mem_rdata;

  // Query context: capture the request, square the move, latch the querying sphere.
  // A full-scale negative component squares to 2^46, so each square keeps 47 bits.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r <= in_slot;
      vx_r   <= in_vec_x;
      vy_r   <= in_vec_y;
      vz_r   <= in_vec_z;
    end
    sqx_r <= 47'(vx_r * vx_r);
    sqy_r <= 47'(vy_r * vy_r);
    sqz_r <= 47'(vz_r * vz_r);
    if (cmd.capture_q) begin
      qx_r  <= mx;
      qy_r  <= my;
      qz_r  <= mz;
      r1_r  <= mr;
      dd_r  <= 48'(sqx_r) + 48'(sqy_r) + 48'(sqz_r);
    end
  end

  // Scan counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign status.scan_done = LW'(idx_r) >= limit;
  assign status.pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r || v6_r;
  assign status.out_busy  = out_valid_r && !out_ready;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 1: offset from the querying sphere and radius sum.
  always_ff @(posedge clk) begin
    i1_r <= idx_r;
    k1_r <= LW'(idx_r) == LW'(slot_r);
    i2_r <= i1_r;
    k2_r <= k1_r;
    px_r <= 25'(mx) - 25'(qx_r);
    py_r <= 25'(my) - 25'(qy_r);
    pz_r <= 25'(mz) - 25'(qz_r);
    rs_r <= 9'(r1_r) + 9'(mr);
  end

  // Stage 2: component products and radius sum squared.
  always_ff @(posedge clk) begin
    i3_r   <= i2_r;
    k3_r   <= k2_r;
    pxvx_r <= px_r * vx_r;
    pyvy_r <= py_r * vy_r;
    pzvz_r <= pz_r * vz_r;
    pyvz_r <= py_r * vz_r;
    pzvy_r <= pz_r * vy_r;
    pzvx_r <= pz_r * vx_r;
    pxvz_r <= px_r * vz_r;
    pxvy_r <= px_r * vy_r;
    pyvx_r <= py_r * vx_r;
    r2_r   <= 18'(rs_r * rs_r);
  end

  // Stage 3: dot and cross products, bound partial products.
  always_ff @(posedge clk) begin
    i4_r  <= i3_r;
    k4_r  <= k3_r;
    dot_r <= 51'(pxvx_r) + 51'(pyvy_r) + 51'(pzvz_r);
    cx_r  <= 50'(pyvz_r) - 50'(pzvy_r);
    cy_r  <= 50'(pzvx_r) - 50'(pxvz_r);
    cz_r  <= 50'(pxvy_r) - 50'(pyvx_r);
    bl_r  <= 42'(r2_r * dd_r[23:0]);
    bh_r  <= 42'(r2_r * dd_r[47:24]);
  end

  // Stage 4: magnitudes, split squares of the cross terms, bound.
  assign proj4 = 50'(dot_r[50] ? -dot_r : dot_r);
  assign cmx   = 49'(cx_r[49] ? -cx_r : cx_r);
  assign cmy   = 49'(cy_r[49] ? -cy_r : cy_r);
  assign cmz   = 49'(cz_r[49] ? -cz_r : cz_r);

  always_ff @(posedge clk) begin
    i5_r     <= i4_r;
    k5_r     <= k4_r;
    proj5_r  <= proj4;
    hhx_r    <= cmx[48:25] * cmx[48:25];
    hhy_r    <= cmy[48:25] * cmy[48:25];
    hhz_r    <= cmz[48:25] * cmz[48:25];
    hlx_r    <= cmx[48:25] * cmx[24:0];
    hly_r    <= cmy[48:25] * cmy[24:0];
    hlz_r    <= cmz[48:25] * cmz[24:0];
    llx_r    <= cmx[24:0] * cmx[24:0];
    lly_r    <= cmy[24:0] * cmy[24:0];
    llz_r    <= cmz[24:0] * cmz[24:0];
    bound5_r <= {(66'(bh_r) << 24) + 66'(bl_r), 16'd0};
  end

  // Stage 5: squared perpendicular length and reach test.
  always_ff @(posedge clk) begin
    i6_r     <= i5_r;
    k6_r     <= k5_r;
    proj6_r  <= proj5_r;
    reach6_r <= proj5_r < 50'(dd_r);
    bound6_r <= 102'(bound5_r);
    cross6_r <= (102'(hhx_r) << 50) + (102'(hlx_r) << 26) + 102'(llx_r)
              + (102'(hhy_r) << 50) + (102'(hly_r) << 26) + 102'(lly_r)
              + (102'(hhz_r) << 50) + (102'(hlz_r) << 26) + 102'(llz_r);
  end

  // Stage 6: path test and nearest candidate update; ties keep the lower slot.
  assign pass6 = v6_r && !k6_r && reach6_r && (cross6_r < bound6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      found_r <= 1'b0;
    end else if (pass6 && (!found_r || proj6_r < best_proj_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pass6 && (!found_r || proj6_r < best_proj_r)) begin
      best_r      <= i6_r;
      best_proj_r <= proj6_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_hit_r  <= found_r;
      out_slot_r <= found_r ? SLOT_W'(best_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_nearest_slot = out_slot_r;

endmodule

// ----- src/nearest_sphere_on_ray.sv -----
// Top level of the nearest sphere on ray search block.
// Depends on nsr_pkg, nsr_ctrl and nsr_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): a request either loads a sphere
//   (in_kind 0: position in_vec_*, in_radius into table slot in_slot) or
//   queries from slot in_slot with move vector in_vec_*.
//   Result channel (out_valid/out_ready): one result per query, none per
//   load: out_hit and out_nearest_slot (0 when nothing is hit).
//   Configuration: cfg_we writes cfg_active_count, the number of occupied
//   slots, in the same cycle; write it only while the block is idle.
// Timing:
//   A load writes the table when taken. A query scans N slots, N being the
//   active slot count capped at SLOTS: the single table read port visits one
//   slot per cycle, followed by the six-stage test pipeline draining.
//   One request is worked on at a time.
// Reset and stall:
//   Reset empties the pipeline and result register and clears the active
//   count; table contents are undefined until loaded. A stalled receiver
//   holds the result; the next request is still taken, and a finished query
//   waits for the result register to free up.
`timescale 1ns / 1ps

module nearest_sphere_on_ray
  import nsr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_active_count,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  input  logic [RAD_W-1:0]        in_radius,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [SLOT_W-1:0]       out_nearest_slot
);

  cmd_t    cmd;
  status_t status;
  logic    slot_ok;

  // Sequencing.
  nsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_slot_ok (slot_ok),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Table, arithmetic and result register.
  nsr_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_active_count (cfg_active_count),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_vec_x         (in_vec_x),
    .in_vec_y         (in_vec_y),
    .in_vec_z         (in_vec_z),
    .in_radius        (in_radius),
    .in_slot_ok       (slot_ok),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_nearest_slot (out_nearest_slot)
  );

endmodule

// ----- src/nsr_checker.sv -----
// Port-level checks for nearest_sphere_on_ray, attached by bind.
// Depends on nsr_pkg for field widths.
`timescale 1ns / 1ps

module nsr_checker
  import nsr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [SLOT_W-1:0] out_nearest_slot
);

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_nearest_slot))
    else $error("result changed while stalled");

  // A miss reports slot zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_nearest_slot == '0)
    else $error("miss with nonzero slot");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result never appears in the cycle right after a request is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

endmodule

bind nearest_sphere_on_ray nsr_checker u_nsr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit          (out_hit),
  .out_nearest_slot (out_nearest_slot)
);
